@@ hw/rtl/lra_pkg.sv @@
// Shared constants, codes and types for the line rasterizer.
// No dependencies; every other file of the block refers to this package.
package lra_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int REG_BITS       = 15;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = 15'd800;
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = 15'd600;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    // Direction and axis selection of the segment in progress.
    typedef struct packed {
        logic row_dir_neg;
        logic col_dir_neg;
        logic col_is_major;
    } dir_t;

endpackage

@@ hw/rtl/lra_cmd_if.sv @@
// Command channel of the line rasterizer: opcode and segment endpoints.
// Depends on lra_pkg for the opcode type.
interface lra_cmd_if #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    lra_pkg::opcode_t             opcode;
    logic signed [COORD_BITS-1:0] src_row;
    logic signed [COORD_BITS-1:0] src_col;
    logic signed [COORD_BITS-1:0] dst_row;
    logic signed [COORD_BITS-1:0] dst_col;

    modport source (output valid, opcode, src_row, src_col, dst_row, dst_col, input ready);
    modport sink   (input valid, opcode, src_row, src_col, dst_row, dst_col, output ready);
endinterface

@@ hw/rtl/lra_pix_if.sv @@
// Pixel channel of the line rasterizer: one pixel with its flags per beat.
// Depends on lra_pkg for the default coordinate width.
interface lra_pix_if #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_row;
    logic signed [COORD_BITS-1:0] pixel_col;
    logic                         pixel_visible;
    logic                         segment_last;
    logic                         no_pixel;

    modport source (output valid, pixel_row, pixel_col, pixel_visible, segment_last, no_pixel,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, pixel_visible, segment_last, no_pixel,
                    output ready);
endinterface

@@ hw/rtl/lra_setup.sv @@
// Segment set-up: axis distances, step signs, major axis and initial error.
// Depends on lra_pkg for the direction struct.
module lra_setup #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] src_row,
    input  logic [COORD_BITS-1:0] src_col,
    input  logic [COORD_BITS-1:0] dst_row,
    input  logic [COORD_BITS-1:0] dst_col,
    output logic [COORD_BITS:0]   major_len,
    output logic [COORD_BITS:0]   minor_len,
    output logic [COORD_BITS+1:0] error_init,
    output lra_pkg::dir_t         dir
);
    logic [COORD_BITS:0] diff_row;
    logic [COORD_BITS:0] diff_col;
    logic [COORD_BITS:0] abs_row;
    logic [COORD_BITS:0] abs_col;

    // Differences are taken one bit wider so that they cannot overflow.
    assign diff_row = {dst_row[COORD_BITS-1], dst_row} - {src_row[COORD_BITS-1], src_row};
    assign diff_col = {dst_col[COORD_BITS-1], dst_col} - {src_col[COORD_BITS-1], src_col};

    assign abs_row = diff_row[COORD_BITS] ? (~diff_row + 1'b1) : diff_row;
    assign abs_col = diff_col[COORD_BITS] ? (~diff_col + 1'b1) : diff_col;

    // A zero difference steps in the negative direction, as does a negative one.
    assign dir.row_dir_neg  = diff_row[COORD_BITS] || (diff_row == '0);
    assign dir.col_dir_neg  = diff_col[COORD_BITS] || (diff_col == '0);
    assign dir.col_is_major = abs_col > abs_row;

    assign major_len  = dir.col_is_major ? abs_col : abs_row;
    assign minor_len  = dir.col_is_major ? abs_row : abs_col;
    assign error_init = {2'b00, major_len[COORD_BITS:1]};
endmodule

@@ hw/rtl/lra_step.sv @@
// One Bresenham step: error update and the move of both coordinates.
// Depends on lra_pkg for the direction struct.
module lra_step #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] cur_row,
    input  logic [COORD_BITS-1:0] cur_col,
    input  logic [COORD_BITS+1:0] error_term,
    input  logic [COORD_BITS:0]   major_len,
    input  logic [COORD_BITS:0]   minor_len,
    input  lra_pkg::dir_t         dir,
    output logic [COORD_BITS-1:0] next_row,
    output logic [COORD_BITS-1:0] next_col,
    output logic [COORD_BITS+1:0] next_error
);
    logic [COORD_BITS+1:0] error_sum;
    logic                  minor_move;
    logic [COORD_BITS-1:0] row_moved;
    logic [COORD_BITS-1:0] col_moved;

    assign error_sum  = error_term + {1'b0, minor_len};
    assign minor_move = error_sum >= {1'b0, major_len};
    assign next_error = minor_move ? error_sum - {1'b0, major_len} : error_sum;

    assign row_moved = dir.row_dir_neg ? cur_row - 1'b1 : cur_row + 1'b1;
    assign col_moved = dir.col_dir_neg ? cur_col - 1'b1 : cur_col + 1'b1;

    // The major coordinate always moves; the minor one only on an error carry.
    assign next_col = (dir.col_is_major || minor_move) ? col_moved : cur_col;
    assign next_row = (!dir.col_is_major || minor_move) ? row_moved : cur_row;
endmodule

@@ hw/rtl/lra_clip.sv @@
// Clip test: a pixel is visible strictly inside the window (0, width) x (0, height).
// Depends on lra_pkg for the register width.
module lra_clip #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]        row,
    input  logic [COORD_BITS-1:0]        col,
    input  logic [lra_pkg::REG_BITS-1:0] screen_width,
    input  logic [lra_pkg::REG_BITS-1:0] screen_height,
    output logic                         visible
);
    // Comparisons are made in a signed width that holds both operands.
    localparam int CMP_BITS = ((COORD_BITS > lra_pkg::REG_BITS) ?
                               COORD_BITS : lra_pkg::REG_BITS) + 1;

    logic signed [CMP_BITS-1:0] row_ext;
    logic signed [CMP_BITS-1:0] col_ext;
    logic signed [CMP_BITS-1:0] width_ext;
    logic signed [CMP_BITS-1:0] height_ext;

    assign row_ext    = CMP_BITS'($signed(row));
    assign col_ext    = CMP_BITS'($signed(col));
    assign width_ext  = $signed(CMP_BITS'(screen_width));
    assign height_ext = $signed(CMP_BITS'(screen_height));

    assign visible = (col_ext > 0) && (col_ext < width_ext) &&
                     (row_ext > 0) && (row_ext < height_ext);
endmodule

@@ hw/rtl/line_rasterizer_unit.sv @@
// Top level of the line rasterizer: state registers, output register, config registers.
// Depends on lra_pkg, lra_cmd_if, lra_pix_if, lra_setup, lra_step and lra_clip.
//
// Usage:
//   cmd carries one command per beat. A start command loads a segment from its
//   endpoints and returns the source pixel; each step command advances one pixel
//   along the segment. pix returns exactly one beat for every command: the pixel,
//   its clip flag, a last-pixel flag, and no_pixel for a step with no segment.
//   cfg_we/cfg_index/cfg_data write screen_width (index 0) and screen_height
//   (index 1); write them only while no command is outstanding.
// Timing:
//   A command is processed in the cycle it is accepted and its result is held in
//   the output register from the next cycle. The step recurrence (one add,
//   compare and subtract on the error term) is combinational, so one command
//   is taken per cycle while pix is not stalled.
// Reset and stalls:
//   Reset clears the segment state (no segment active) and loads 800 x 600 into
//   the window registers. While pix is stalled with a result held, cmd.ready is
//   low; it rises in the same cycle that the held beat is taken.
module line_rasterizer_unit #(
    parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    lra_cmd_if.sink                      cmd,
    lra_pix_if.source                    pix,
    input  logic                         cfg_we,
    input  lra_pkg::reg_index_t          cfg_index,
    input  logic [lra_pkg::REG_BITS-1:0] cfg_data
);
    logic [lra_pkg::REG_BITS-1:0] screen_width_reg;
    logic [lra_pkg::REG_BITS-1:0] screen_height_reg;

    logic [COORD_BITS-1:0] cur_row_reg,    cur_row_next;
    logic [COORD_BITS-1:0] cur_col_reg,    cur_col_next;
    logic [COORD_BITS+1:0] error_term_reg, error_term_next;
    logic [COORD_BITS:0]   major_len_reg,  major_len_next;
    logic [COORD_BITS:0]   minor_len_reg,  minor_len_next;
    logic [COORD_BITS:0]   steps_left_reg, steps_left_next;
    lra_pkg::dir_t         dir_reg,        dir_next;
    logic                  active_reg,     active_next;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_row_reg,     out_row_next;
    logic [COORD_BITS-1:0] out_col_reg,     out_col_next;
    logic                  out_visible_reg, out_visible_next;
    logic                  out_last_reg,    out_last_next;
    logic                  out_none_reg,    out_none_next;

    logic                  cmd_accept;

    logic [COORD_BITS:0]   setup_major;
    logic [COORD_BITS:0]   setup_minor;
    logic [COORD_BITS+1:0] setup_error;
    lra_pkg::dir_t         setup_dir;

    logic [COORD_BITS-1:0] step_row;
    logic [COORD_BITS-1:0] step_col;
    logic [COORD_BITS+1:0] step_error;

    lra_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .src_row    (cmd.src_row),
        .src_col    (cmd.src_col),
        .dst_row    (cmd.dst_row),
        .dst_col    (cmd.dst_col),
        .major_len  (setup_major),
        .minor_len  (setup_minor),
        .error_init (setup_error),
        .dir        (setup_dir)
    );

    lra_step #(.COORD_BITS(COORD_BITS)) u_step (
        .cur_row    (cur_row_reg),
        .cur_col    (cur_col_reg),
        .error_term (error_term_reg),
        .major_len  (major_len_reg),
        .minor_len  (minor_len_reg),
        .dir        (dir_reg),
        .next_row   (step_row),
        .next_col   (step_col),
        .next_error (step_error)
    );

    lra_clip #(.COORD_BITS(COORD_BITS)) u_clip (
        .row           (out_row_next),
        .col           (out_col_next),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .visible       (out_visible_next)
    );

    // A new command is taken whenever the output register is empty or being emptied.
    assign cmd.ready  = !out_valid_reg || pix.ready;
    assign cmd_accept = cmd.valid && cmd.ready;

    always_comb
    begin
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        error_term_next = error_term_reg;
        major_len_next  = major_len_reg;
        minor_len_next  = minor_len_reg;
        steps_left_next = steps_left_reg;
        dir_next        = dir_reg;
        active_next     = active_reg;
        out_row_next    = '0;
        out_col_next    = '0;
        out_last_next   = 1'b0;
        out_none_next   = 1'b0;
        unique case (cmd.opcode)
            lra_pkg::OP_START:
            begin
                cur_row_next    = cmd.src_row;
                cur_col_next    = cmd.src_col;
                error_term_next = setup_error;
                major_len_next  = setup_major;
                minor_len_next  = setup_minor;
                steps_left_next = setup_major;
                dir_next        = setup_dir;
                active_next     = setup_major != '0;
                out_row_next    = cmd.src_row;
                out_col_next    = cmd.src_col;
                out_last_next   = setup_major == '0;
            end
            lra_pkg::OP_STEP:
            begin
                if (active_reg)
                begin
                    cur_row_next    = step_row;
                    cur_col_next    = step_col;
                    error_term_next = step_error;
                    steps_left_next = steps_left_reg - 1'b1;
                    active_next     = steps_left_reg != (COORD_BITS+1)'(1);
                    out_row_next    = step_row;
                    out_col_next    = step_col;
                    out_last_next   = steps_left_reg == (COORD_BITS+1)'(1);
                end
                else
                begin
                    out_none_next = 1'b1;
                end
            end
            default:
            begin
                out_none_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            error_term_reg <= '0;
            major_len_reg  <= '0;
            minor_len_reg  <= '0;
            steps_left_reg <= '0;
            dir_reg        <= '0;
            active_reg     <= 1'b0;
        end
        else if (cmd_accept)
        begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            error_term_reg <= error_term_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            steps_left_reg <= steps_left_next;
            dir_reg        <= dir_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The visible flag of a no-pixel beat is zero because the clip sees the origin.
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            out_row_reg     <= out_row_next;
            out_col_reg     <= out_col_next;
            out_visible_reg <= out_visible_next;
            out_last_reg    <= out_last_next;
            out_none_reg    <= out_none_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= lra_pkg::WIDTH_RESET;
            screen_height_reg <= lra_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lra_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                lra_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:                    screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    assign pix.valid         = out_valid_reg;
    assign pix.pixel_row     = out_row_reg;
    assign pix.pixel_col     = out_col_reg;
    assign pix.pixel_visible = out_visible_reg;
    assign pix.segment_last  = out_last_reg;
    assign pix.no_pixel      = out_none_reg;

`ifndef SYNTHESIS
    a_active_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (steps_left_reg != '0))
        else $error("segment active flag disagrees with the remaining step count");

    a_error_below_major: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (error_term_reg < {1'b0, major_len_reg}))
        else $error("error term reached the major length during a segment");

    a_no_pixel_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.no_pixel) |->
            (pix.pixel_row == '0 && pix.pixel_col == '0 &&
             !pix.pixel_visible && !pix.segment_last))
        else $error("no-pixel beat carries pixel data");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pix.ready) |-> !cmd_accept)
        else $error("command accepted while a stalled result is held");

    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_accept && out_last_next) |=> !active_reg)
        else $error("segment still active after its last pixel");
`endif
endmodule
